// ===== rtl/base64_stream_decoder_top_macros.svh =====
// assertion macros for the base64 stream decoder
// used by base64_stream_decoder_top, expects a clock clk and a reset rst in scope
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

// implication property checked on every clock edge outside reset
`define B64D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be true outside reset
`define B64D_NEVER(label, cond, msg) \
  `B64D_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/b64d_pkg.sv =====
// shared types and helpers for the base64 stream decoder
// no dependencies; imported by every module of the block
package b64d_pkg;

  localparam int unsigned SEXTET_W = 6;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned QDEPTH   = 4;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] CHAR_D0    = 8'h30;
  localparam logic [7:0] CHAR_D9    = 8'h39;

  localparam logic [1:0] POS_LAST = 2'd3;

  // one queued unit of work for the back end: a decoded quartet or a bare end marker
  typedef struct packed {
    logic [23:0]        word;
    logic [2:0]         mask;      // bit 2 first byte, bit 0 third byte
    logic               msg_end;
    logic               err;
    logic [TOTAL_W-1:0] total;
  } b64d_entry_t;

  // front status seen by the top level checks
  typedef struct packed {
    logic [1:0] pos;
    logic       err_latch;
  } b64d_front_stat_t;

  // {bad, value}: bad set when the character is outside the alphabet
  function automatic logic [SEXTET_W:0] sextet_of(input logic [7:0] ch);
    logic [SEXTET_W:0] r;
    r = {1'b1, 6'd0};
    if (ch >= CHAR_UA && ch <= CHAR_UZ) r = {1'b0, 6'(ch - CHAR_UA)};
    else if (ch >= CHAR_LA && ch <= CHAR_LZ) r = {1'b0, 6'(ch - CHAR_LA + 8'd26)};
    else if (ch >= CHAR_D0 && ch <= CHAR_D9) r = {1'b0, 6'(ch - CHAR_D0 + 8'd52)};
    else if (ch == CHAR_PLUS) r = {1'b0, 6'd62};
    else if (ch == CHAR_SLASH) r = {1'b0, 6'd63};
    return r;
  endfunction

endpackage

// ===== rtl/b64d_front.sv =====
// front end: accepts characters, assembles quartets, keeps error and byte count
// depends on b64d_pkg; feeds b64d_queue
module b64d_front
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       char_code,
  input  logic             is_final,
  output logic             push,
  output b64d_entry_t      entry,
  output b64d_front_stat_t stat
);

  logic [1:0]             pos, pos_next;
  logic [17:0]            store, store_next;
  logic                   third_pad, third_pad_next;
  logic                   err_latch, err_latch_next;
  logic [COUNT_WIDTH-1:0] count, count_next;

  logic [SEXTET_W:0]      sx;
  logic                   pad, pad_ok, err_now;
  logic [SEXTET_W-1:0]    v;
  logic [2:0]             mask;
  logic [1:0]             nbytes;
  logic [COUNT_WIDTH+1:0] sum;
  logic [COUNT_WIDTH-1:0] count_sat;
  logic [32:0]            count_ext;

  localparam logic [COUNT_WIDTH+1:0] COUNT_MAX = {2'b00, {COUNT_WIDTH{1'b1}}};

  always_comb begin
    sx      = sextet_of(char_code);
    pad     = (char_code == CHAR_PAD);
    pad_ok  = (pos >= 2'd2) && pad;
    err_now = !pad_ok && sx[SEXTET_W];
    v       = (pad_ok || sx[SEXTET_W]) ? '0 : sx[SEXTET_W-1:0];
    mask    = {1'b1, !third_pad, !pad};
    nbytes  = (pos == POS_LAST) ? (2'd1 + 2'(!third_pad) + 2'(!pad)) : 2'd0;
    sum     = (COUNT_WIDTH+2)'(count) + (COUNT_WIDTH+2)'(nbytes);
    count_sat = (sum > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0] : sum[COUNT_WIDTH-1:0];
    count_ext = 33'(count_sat);

    entry.word    = {store, v};
    entry.mask    = (pos == POS_LAST) ? mask : 3'b000;
    entry.msg_end = is_final;
    entry.err     = err_latch || err_now;
    entry.total   = (count_ext > 33'hFFFF) ? {TOTAL_W{1'b1}} : count_ext[TOTAL_W-1:0];
    push          = accept && ((pos == POS_LAST) || is_final);

    pos_next       = pos;
    store_next     = store;
    third_pad_next = third_pad;
    err_latch_next = err_latch;
    count_next     = count;
    if (accept) begin
      err_latch_next = err_latch || err_now;
      count_next     = count_sat;
      if (pos == POS_LAST) begin
        pos_next       = 2'd0;
        store_next     = '0;
        third_pad_next = 1'b0;
      end else begin
        pos_next   = pos + 2'd1;
        store_next = {store[11:0], v};
        if (pos == 2'd2) third_pad_next = pad;
      end
      if (is_final) begin
        pos_next       = 2'd0;
        store_next     = '0;
        third_pad_next = 1'b0;
        err_latch_next = 1'b0;
        count_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      store     <= '0;
      third_pad <= 1'b0;
      err_latch <= 1'b0;
      count     <= '0;
    end else begin
      pos       <= pos_next;
      store     <= store_next;
      third_pad <= third_pad_next;
      err_latch <= err_latch_next;
      count     <= count_next;
    end
  end

  assign stat.pos       = pos;
  assign stat.err_latch = err_latch;

endmodule

// ===== rtl/b64d_queue.sv =====
// short queue of decoded quartets between front and back end
// depends on b64d_pkg
module b64d_queue
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  b64d_entry_t din,
  input  logic        pop,
  output b64d_entry_t dout,
  output logic        full,
  output logic        empty
);

  localparam int unsigned AW = $clog2(QDEPTH);

  b64d_entry_t    slots [QDEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    fill;

  assign full  = (fill == (AW+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== rtl/b64d_back.sv =====
// back end: splits each queued quartet into byte results behind an output register
// depends on b64d_pkg; reads b64d_queue
module b64d_back
  import b64d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  b64d_entry_t        head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         data_byte,
  output logic               byte_valid,
  output logic               end_of_message,
  output logic               decode_error,
  output logic [TOTAL_W-1:0] total_bytes
);

  logic [2:0] sent;
  logic [2:0] pending, pick, rest;
  logic [7:0] sel_byte;
  logic       load, last;

  always_comb begin
    pending  = head.mask & ~sent;
    pick     = 3'b000;
    sel_byte = 8'd0;
    priority if (pending[2]) begin
      pick     = 3'b100;
      sel_byte = head.word[23:16];
    end else if (pending[1]) begin
      pick     = 3'b010;
      sel_byte = head.word[15:8];
    end else if (pending[0]) begin
      pick     = 3'b001;
      sel_byte = head.word[7:0];
    end else begin
      // bare end marker, or nothing queued
      pick     = 3'b000;
      sel_byte = 8'd0;
    end
    rest = pending & ~pick;
    last = (rest == 3'b000);
    load = !empty && (!out_valid || !out_stall);
    pop  = load && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        sent      <= last ? 3'b000 : (sent | pick);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte      <= sel_byte;
      byte_valid     <= |pick;
      end_of_message <= last && head.msg_end;
      decode_error   <= last && head.msg_end && head.err;
      total_bytes    <= (last && head.msg_end) ? head.total : '0;
    end
  end

endmodule

// ===== rtl/base64_stream_decoder_top.sv =====
// top level of the base64 stream decoder
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back and the assertion macro header
`include "base64_stream_decoder_top_macros.svh"

// base64 text decoder, standard alphabet, one character per transaction on the input
// side. throughput is one character per clock while the queue has room: the front
// end updates the quartet state on each accepted character, and the back end hands
// out one result per clock from an output register while the output is not stalled,
// so four characters (at most three bytes) never outrun it. a decoded quartet
// travels through a four entry queue as one word with a byte mask; the back end
// then emits its one to three bytes, most significant first. the first byte passes
// from the queue through the output register to the output. the input stalls only
// when the queue is full, which happens only after the output side has stalled.
// a final character that leaves a partial quartet gives a single end result with
// byte_valid low; otherwise the end flags, error flag and byte total ride on the
// last byte of the quartet. results other than the end result show zero error and
// zero total. all quartet state, the error latch and the byte counter clear after
// the final character, so the next message starts clean.
module base64_stream_decoder_top
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  input  logic               is_final,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         data_byte,
  output logic               byte_valid,
  output logic               end_of_message,
  output logic               decode_error,
  output logic [TOTAL_W-1:0] total_bytes
);

  logic             accept;
  logic             push, pop, full, empty;
  b64d_entry_t      entry, head;
  b64d_front_stat_t fstat;

  // conditions watched by the checks at the end
  logic             fin_taken, front_clean, mid_fields_set, empty_unclean;

  // input transaction completes when the queue has room
  assign in_stall = full;
  assign accept   = in_valid && !full;

  b64d_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .is_final  (is_final),
    .push      (push),
    .entry     (entry),
    .stat      (fstat)
  );

  b64d_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty)
  );

  b64d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .decode_error   (decode_error),
    .total_bytes    (total_bytes)
  );

  assign fin_taken      = accept && is_final;
  assign front_clean    = (fstat.pos == 2'd0) && !fstat.err_latch;
  assign mid_fields_set = out_valid && !end_of_message && (decode_error || total_bytes != '0);
  assign empty_unclean  = out_valid && !byte_valid && (data_byte != 8'd0 || !end_of_message);

  // a final character always leaves the front end at the start of a clean quartet
  `B64D_ASSERT(a_final_clears, fin_taken |=> front_clean, "front not cleared after final")
  // only the end result carries the error flag and the byte total
  `B64D_NEVER(a_mid_fields, mid_fields_set, "error or total on a result that is not the end")
  // a result without a byte shows a zero data byte and must be an end result
  `B64D_NEVER(a_empty_result, empty_unclean, "empty result that is not a clean end result")

endmodule

// ===== tb/b64d_decode_checker.sv =====
// checker for the base64 stream decoder: watches both channels, predicts and compares
// depends on b64d_pkg for the character codes, quartet positions and total width
module b64d_decode_checker
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         char_code,
  input  logic               is_final,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         data_byte,
  input  logic               byte_valid,
  input  logic               end_of_message,
  input  logic               decode_error,
  input  logic [TOTAL_W-1:0] total_bytes,
  output int                 failures,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] POS_THIRD = 2'd2;

  typedef struct packed {
    logic [7:0]         data;
    logic               valid;
    logic               eom;
    logic               err;
    logic [TOTAL_W-1:0] total;
  } b64d_result_t;

  b64d_result_t results_due[$];
  b64d_result_t want;

  // decoder state as predicted
  logic [1:0]             slot;
  logic [17:0]            held_sextets;
  logic                   third_pad;
  logic                   bad_seen;
  logic [COUNT_WIDTH-1:0] bytes_decoded;
  int                     fail_count = 0;

  // {bad, value} of one character
  function automatic logic [6:0] sextet_value(input logic [7:0] ch);
    if (ch >= CHAR_UA && ch <= CHAR_UZ) return {1'b0, 6'(ch - CHAR_UA)};
    if (ch >= CHAR_LA && ch <= CHAR_LZ) return {1'b0, 6'(ch - CHAR_LA + 8'd26)};
    if (ch >= CHAR_D0 && ch <= CHAR_D9) return {1'b0, 6'(ch - CHAR_D0 + 8'd52)};
    if (ch == CHAR_PLUS) return {1'b0, 6'd62};
    if (ch == CHAR_SLASH) return {1'b0, 6'd63};
    return {1'b1, 6'd0};
  endfunction

  task automatic clear_message();
    slot          = '0;
    held_sextets  = '0;
    third_pad     = 1'b0;
    bad_seen      = 1'b0;
    bytes_decoded = '0;
  endtask

  // one accepted character: update the quartet and queue the results it causes
  task automatic decode_char(input logic [7:0] ch, input logic fin);
    b64d_result_t got_out [3];
    logic [6:0]   sx;
    logic         pad;
    logic [5:0]   val;
    logic [23:0]  word;
    logic [2:0]   keep;
    int           n;
    n   = 0;
    pad = (ch == CHAR_PAD);
    sx  = sextet_value(ch);
    val = sx[5:0];
    if (slot >= POS_THIRD && pad) begin
      val = '0;
    end else if (sx[6]) begin
      bad_seen = 1'b1;
      val      = '0;
    end
    if (slot != POS_LAST) begin
      held_sextets = {held_sextets[11:0], val};
      if (slot == POS_THIRD) third_pad = pad;
      slot = slot + 2'd1;
    end else begin
      word = {held_sextets, val};
      keep = {1'b1, !third_pad, !pad};
      for (int k = 0; k < 3; k++) begin
        if (keep[2-k]) begin
          got_out[n]       = '0;
          got_out[n].data  = word[23-8*k -: 8];
          got_out[n].valid = 1'b1;
          n++;
          if (bytes_decoded != '1) bytes_decoded = bytes_decoded + 1'b1;
        end
      end
      slot         = '0;
      held_sextets = '0;
      third_pad    = 1'b0;
    end
    if (fin) begin
      if (n == 0) begin
        got_out[0] = '0;
        n = 1;
      end
      got_out[n-1].eom   = 1'b1;
      got_out[n-1].err   = bad_seen;
      got_out[n-1].total = (bytes_decoded > {TOTAL_W{1'b1}}) ? '1 : TOTAL_W'(bytes_decoded);
      clear_message();
    end
    for (int i = 0; i < n; i++) results_due.push_back(got_out[i]);
  endtask

  task automatic check_field(input string field, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $error("%s: expected %0h, actual %0h", field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_message();
      results_due.delete();
    end else begin
      if (in_valid && !in_stall) decode_char(char_code, is_final);
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          fail_count++;
          $error("result with nothing expected: data_byte %0h", data_byte);
        end else begin
          want = results_due.pop_front();
          check_field("data_byte", 16'(want.data), 16'(data_byte));
          check_field("byte_valid", 16'(want.valid), 16'(byte_valid));
          check_field("end_of_message", 16'(want.eom), 16'(end_of_message));
          check_field("decode_error", 16'(want.err), 16'(decode_error));
          check_field("total_bytes", 16'(want.total), 16'(total_bytes));
        end
      end
    end
    failures    <= fail_count;
    outstanding <= results_due.size();
  end

endmodule

// ===== tb/testbench.sv =====
// top of the base64 stream decoder testbench: clock, reset, stimulus and verdict
// depends on b64d_pkg, base64_stream_decoder_top and b64d_decode_checker
module testbench;
  import b64d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [7:0] char_q_t[$];

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         char_code = '0;
  logic               is_final = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         data_byte;
  logic               byte_valid;
  logic               end_of_message;
  logic               decode_error;
  logic [TOTAL_W-1:0] total_bytes;

  int failures;
  int outstanding;
  int chars_sent = 0;
  int watchdog_cycles = 0;

  // calm turns off idling on both sides for a whole message
  logic calm = 1'b0;
  int   stall_run = 0;
  int   stall_len;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  base64_stream_decoder_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .is_final       (is_final),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .decode_error   (decode_error),
    .total_bytes    (total_bytes)
  );

  b64d_decode_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .is_final       (is_final),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .decode_error   (decode_error),
    .total_bytes    (total_bytes),
    .failures       (failures),
    .outstanding    (outstanding)
  );

  // idle length: mostly none, sometimes a few cycles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // character for a 6-bit value in the standard alphabet
  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    if (v < 6'd26) return CHAR_UA + 8'(v);
    if (v < 6'd52) return CHAR_LA + 8'(v - 6'd26);
    if (v < 6'd62) return CHAR_D0 + 8'(v - 6'd52);
    if (v == 6'd62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  // receiver side: random stall runs, none while calm
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      stall_len = pick_gap();
      out_stall <= (stall_len > 0);
      stall_run <= (stall_len > 0) ? stall_len - 1 : 0;
    end
  end

  // one character transaction; valid drops only for an idle gap and is then held
  // high with a steady payload until the decoder takes it
  task automatic send_char(input logic [7:0] ch, input logic fin);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= ch;
    is_final  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  // whole message, the final flag on its last character
  task automatic send_message(input char_q_t text);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  // mostly well formed text with random content and padding, now and then a
  // leftover partial quartet, a corrupted character or a message of pure noise
  task automatic send_random_message();
    char_q_t    text;
    logic [7:0] quad [4];
    int         style;
    text = {};
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 9)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 6)) begin
        for (int k = 0; k < 4; k++) quad[k] = b64_symbol(6'($urandom));
        style = $urandom_range(0, 9);
        // two pads, pad in fourth place only, pad in third place only
        if (style == 0) begin
          quad[2] = CHAR_PAD;
          quad[3] = CHAR_PAD;
        end else if (style == 1) begin
          quad[3] = CHAR_PAD;
        end else if (style == 2) begin
          quad[2] = CHAR_PAD;
        end
        for (int k = 0; k < 4; k++) text.push_back(quad[k]);
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) text.push_back(b64_symbol(6'($urandom)));
      if (text.size() == 0) text.push_back(b64_symbol(6'($urandom)));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          text[$urandom_range(0, text.size() - 1)] =
            ($urandom_range(0, 1) == 1) ? CHAR_PAD : 8'($urandom_range(0, 255));
        end
      end
    end
    send_message(text);
  endtask

  // watchdog: a stuck handshake or a lost result ends the run here
  initial begin
    while (watchdog_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      watchdog_cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    char_q_t msg;
    int      random_start;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full quartet of all ones, pad in the second place (invalid),
    // pad in third place only, a one-pad quartet, final completing a quartet
    msg = '{"/", "/", "/", "/", "A", "=", "+", "/",
            "T", "Q", "=", "u", "T", "W", "E", "="};
    send_message(msg);
    // pad in the first place, a code above 127, then a final partial quartet
    msg = '{CHAR_PAD, 8'hFF, "9", "a", "Z", "z", "0"};
    send_message(msg);

    // random messages, some of them with no idling at all
    random_start = chars_sent;
    while (chars_sent < random_start + RANDOM_ITEMS) begin
      calm <= ($urandom_range(0, 5) == 0);
      send_random_message();
    end
    calm     <= 1'b0;
    in_valid <= 1'b0;

    // wait for every expected transaction, then a few more cycles for strays
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
